### hdl/dobq_pkg.sv
// Shared types and constants for the drop-oldest byte-budget queue.
package dobq_pkg;

   localparam int TAG_W    = 32;
   localparam int LEN_W    = 16;
   localparam int BYTES_W  = 22;
   localparam int LIMIT_W  = 7;
   localparam int CNT_OUT_W = 7;
   localparam int DROP_W   = 32;
   localparam int ACT_W    = 2;

   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 32;

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 120;

   localparam logic [ACT_W-1:0] ACT_ENQUEUE = 2'd0;
   localparam logic [ACT_W-1:0] ACT_DEQUEUE = 2'd1;

   localparam logic [CSR_INDEX_W-1:0] REG_ENTRY_LIMIT = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_BYTE_BUDGET = 8'd1;

   localparam logic [LIMIT_W-1:0] ENTRY_LIMIT_RESET = 7'd64;
   localparam logic [BYTES_W-1:0] BYTE_BUDGET_RESET = 22'd1048576;

   typedef struct packed {
      logic [DROP_W-1:0]    total_dropped;
      logic [BYTES_W-1:0]   bytes_held;
      logic                 is_empty;
      logic [CNT_OUT_W-1:0] entry_count;
      logic [CNT_OUT_W-1:0] evicted;
      logic [LEN_W-1:0]     out_bytes;
      logic [TAG_W-1:0]     out_tag;
      logic                 accepted;
   } rsp_type;

endpackage

### hdl/dobq_store.sv
// Entry store: tag and length memories, one write port and one registered read port.
module dobq_store #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [AW-1:0]            wr_addr,
   input  logic [dobq_pkg::TAG_W-1:0] wr_tag,
   input  logic [dobq_pkg::LEN_W-1:0] wr_len,
   input  logic [AW-1:0]            rd_addr,
   output logic [dobq_pkg::TAG_W-1:0] rd_tag,
   output logic [dobq_pkg::LEN_W-1:0] rd_len
);

   logic [dobq_pkg::TAG_W-1:0] tag_mem [DEPTH];
   logic [dobq_pkg::LEN_W-1:0] len_mem [DEPTH];
   logic [dobq_pkg::TAG_W-1:0] rd_tag_ff;
   logic [dobq_pkg::LEN_W-1:0] rd_len_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         tag_mem[wr_addr] <= wr_tag;
         len_mem[wr_addr] <= wr_len;
      end
   end

   always_ff @(posedge clock) begin
      rd_tag_ff <= tag_mem[rd_addr];
      rd_len_ff <= len_mem[rd_addr];
   end

   assign rd_tag = rd_tag_ff;
   assign rd_len = rd_len_ff;

endmodule

### hdl/drop_oldest_byte_budget_queue_top.sv
// Top level of the drop-oldest byte-budget queue.
// Sequence: a request is taken in S_IDLE, then passes S_READ, S_EVAL and S_DONE before
//   rsp_tvalid rises; each oldest entry dropped by an enqueue adds another S_READ and S_EVAL pass.
// Flow: one request at a time, taken only in S_IDLE; a result held by
//   rsp_tready keeps req_tready low until the output register frees.
// Reset (synchronous): clears state, head, tail, count, bytes, drop counter and rsp_tvalid, and sets the
//   CSR registers to their defaults; the entry store is not cleared and only held entries are used.
module drop_oldest_byte_budget_queue_top #(
   parameter int DEPTH = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata: entry_tag [31:0], entry_bytes [47:32]
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [dobq_pkg::REQ_DATA_W-1:0]     req_tdata,
   // req_tuser: action [1:0]
   input  logic [dobq_pkg::ACT_W-1:0]          req_tuser,
   // rsp_tdata: accepted [0], out_tag [32:1], out_bytes [48:33], evicted [55:49],
   //   entry_count [62:56], is_empty [63], bytes_held [85:64],
   //   total_dropped [117:86], zero [119:118]
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [dobq_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [dobq_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [dobq_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int LW = (CW > dobq_pkg::LIMIT_W) ? CW : dobq_pkg::LIMIT_W;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_READ = 2'd1;
   localparam logic [1:0] S_EVAL = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   logic [1:0] state_ff, state_in;

   logic [dobq_pkg::LIMIT_W-1:0] entry_limit_ff, entry_limit_in;
   logic [dobq_pkg::BYTES_W-1:0] byte_budget_ff, byte_budget_in;

   logic [dobq_pkg::ACT_W-1:0]  act_ff, act_in;
   logic [dobq_pkg::TAG_W-1:0]  tag_ff, tag_in;
   logic [dobq_pkg::LEN_W-1:0]  len_ff, len_in;

   logic [AW-1:0]                head_ff, head_in;
   logic [AW-1:0]                tail_ff, tail_in;
   logic [CW-1:0]                count_ff, count_in;
   logic [dobq_pkg::BYTES_W-1:0] held_ff, held_in;
   logic [dobq_pkg::DROP_W-1:0]  dropped_ff, dropped_in;
   logic [CW-1:0]                evict_ff, evict_in;

   logic                         res_acc_ff, res_acc_in;
   logic [dobq_pkg::TAG_W-1:0]   res_tag_ff, res_tag_in;
   logic [dobq_pkg::LEN_W-1:0]   res_len_ff, res_len_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   dobq_pkg::rsp_type            rsp_ff, rsp_in;

   logic                         wr_en;
   logic [dobq_pkg::TAG_W-1:0]   rd_tag;
   logic [dobq_pkg::LEN_W-1:0]   rd_len;

   logic [LW-1:0]                lim_raw, lim_eff, count_ext;
   logic [dobq_pkg::BYTES_W:0]   need_bytes;
   logic                         over_limit, over_budget, must_drop;
   logic [AW-1:0]                head_next, tail_next;

   dobq_store #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tail_ff),
      .wr_tag  (tag_ff),
      .wr_len  (len_ff),
      .rd_addr (head_ff),
      .rd_tag  (rd_tag),
      .rd_len  (rd_len)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = dobq_pkg::RSP_DATA_W'(rsp_ff);

   // Clamp the limit into 1..DEPTH.
   always_comb begin
      lim_raw = LW'(entry_limit_ff);
      lim_eff = lim_raw;
      if (lim_raw == '0) begin
         lim_eff = LW'(1);
      end
      if (lim_raw > LW'(DEPTH)) begin
         lim_eff = LW'(DEPTH);
      end
   end

   assign count_ext   = LW'(count_ff);
   assign need_bytes  = {1'b0, held_ff} + (dobq_pkg::BYTES_W + 1)'(len_ff);
   assign over_limit  = (count_ext >= lim_eff);
   assign over_budget = (need_bytes > {1'b0, byte_budget_ff});
   assign must_drop   = (count_ff != '0) && (over_limit || over_budget);
   assign head_next   = (head_ff == AW'(DEPTH - 1)) ? '0 : head_ff + AW'(1);
   assign tail_next   = (tail_ff == AW'(DEPTH - 1)) ? '0 : tail_ff + AW'(1);

   always_comb begin
      entry_limit_in = entry_limit_ff;
      byte_budget_in = byte_budget_ff;
      if (csr_valid) begin
         case (csr_index)
            dobq_pkg::REG_ENTRY_LIMIT:
               entry_limit_in = csr_data[dobq_pkg::LIMIT_W-1:0];
            dobq_pkg::REG_BYTE_BUDGET:
               byte_budget_in = csr_data[dobq_pkg::BYTES_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      act_in       = act_ff;
      tag_in       = tag_ff;
      len_in       = len_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      held_in      = held_ff;
      dropped_in   = dropped_ff;
      evict_in     = evict_ff;
      res_acc_in   = res_acc_ff;
      res_tag_in   = res_tag_ff;
      res_len_in   = res_len_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               act_in     = req_tuser;
               tag_in     = req_tdata[31:0];
               len_in     = req_tdata[47:32];
               evict_in   = '0;
               res_acc_in = 1'b0;
               res_tag_in = '0;
               res_len_in = '0;
               state_in   = S_READ;
            end
         end
         // wait for the head entry to come out of the store
         S_READ: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            if (act_ff == dobq_pkg::ACT_ENQUEUE) begin
               if (must_drop) begin
                  // drop the oldest and look at the next head
                  held_in    = held_ff - dobq_pkg::BYTES_W'(rd_len);
                  count_in   = count_ff - CW'(1);
                  head_in    = head_next;
                  evict_in   = evict_ff + CW'(1);
                  dropped_in = dropped_ff + dobq_pkg::DROP_W'(1);
                  state_in   = S_READ;
               end else begin
                  wr_en      = 1'b1;
                  tail_in    = tail_next;
                  count_in   = count_ff + CW'(1);
                  held_in    = need_bytes[dobq_pkg::BYTES_W-1:0];
                  res_acc_in = 1'b1;
                  state_in   = S_DONE;
               end
            end else if (act_ff == dobq_pkg::ACT_DEQUEUE) begin
               if (count_ff != '0) begin
                  held_in    = held_ff - dobq_pkg::BYTES_W'(rd_len);
                  count_in   = count_ff - CW'(1);
                  head_in    = head_next;
                  res_acc_in = 1'b1;
                  res_tag_in = rd_tag;
                  res_len_in = rd_len;
               end
               state_in = S_DONE;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in         = 1'b1;
               rsp_in.accepted      = res_acc_ff;
               rsp_in.out_tag       = res_tag_ff;
               rsp_in.out_bytes     = res_len_ff;
               rsp_in.evicted       = dobq_pkg::CNT_OUT_W'(evict_ff);
               rsp_in.entry_count   = dobq_pkg::CNT_OUT_W'(count_ff);
               rsp_in.is_empty      = (count_ff == '0);
               rsp_in.bytes_held    = held_ff;
               rsp_in.total_dropped = dropped_ff;
               state_in             = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         entry_limit_ff <= dobq_pkg::ENTRY_LIMIT_RESET;
         byte_budget_ff <= dobq_pkg::BYTE_BUDGET_RESET;
         head_ff        <= '0;
         tail_ff        <= '0;
         count_ff       <= '0;
         held_ff        <= '0;
         dropped_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         entry_limit_ff <= entry_limit_in;
         byte_budget_ff <= byte_budget_in;
         head_ff        <= head_in;
         tail_ff        <= tail_in;
         count_ff       <= count_in;
         held_ff        <= held_in;
         dropped_ff     <= dropped_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff     <= act_in;
      tag_ff     <= tag_in;
      len_ff     <= len_in;
      evict_ff   <= evict_in;
      res_acc_ff <= res_acc_in;
      res_tag_ff <= res_tag_in;
      res_len_ff <= res_len_in;
      rsp_ff     <= rsp_in;
   end

endmodule
